>>> sv/crc8rf_pkg.sv
package crc8rf_pkg;

  // CRC-8 generator x^8+x^2+x+1, zero start value, no reflection.
  localparam logic [7:0] CrcPoly = 8'h07;
  localparam logic [7:0] CrcInit = 8'h00;
  localparam logic       RwReadBit = 1'b1;

  // Command codes carried with each input transaction.
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } crc8rf_cmd_t;

  // Input transaction payload.
  typedef struct packed {
    crc8rf_cmd_t command;
    logic [7:0]  reg_address;
    logic [7:0]  data_byte;
    logic [7:0]  crc_byte;
    logic        first_of_frame;
    logic        last_of_frame;
  } crc8rf_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       crc_ok;
    logic       frame_ok;
    logic       frame_done;
  } crc8rf_out_t;

  // One accepted item, expanded into the bytes it will emit.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            crc_ok;
    logic            frame_ok;
    logic            frame_done;
  } crc8rf_work_t;

  // Shift one byte through the CRC register, MSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> sv/crc8_register_frame_codec_core.sv
// The first result of a transaction passes through the work register and then the output register.
// One result per cycle out of the single output register while out_stall is low; a read gives
// one result, a later write byte two and a first-of-frame write four results per item.
// Reset (rst_n low, synchronous): clears all valid flags, the frame error flag and the
// device address to zero.
module crc8_register_frame_codec_core
  import crc8rf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  crc8rf_in_t  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output crc8rf_out_t out_data,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);

  logic [6:0]   dev_addr_r;
  logic [7:0]   wr_crc_r;
  logic         frame_error_r;
  logic         frame_error_nxt;
  logic         work_vld_r;
  logic         work_vld_nxt;
  logic [1:0]   work_idx_r;
  logic [1:0]   work_idx_nxt;
  crc8rf_work_t work_r;
  crc8rf_work_t work_entry;
  logic         out_vld_r;
  logic         out_vld_nxt;
  crc8rf_out_t  out_r;
  logic         in_acc;
  logic         emit;
  logic         emit_last;

  // Configuration register, with the CRC of the write address kept alongside.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= '0;
      wr_crc_r   <= CrcInit;
    end else if (cfg_wr_en) begin
      dev_addr_r <= cfg_wr_data;
      wr_crc_r   <= crc8_update(CrcInit, {cfg_wr_data, 1'b0});
    end
  end

  // Build the result bytes of the incoming item.
  crc8rf_frame_build u_build (
    .item            (in_data),
    .dev_addr        (dev_addr_r),
    .wr_crc          (wr_crc_r),
    .frame_error     (frame_error_r),
    .entry           (work_entry),
    .frame_error_nxt (frame_error_nxt)
  );

  // Handshake: the work register frees up as its last result moves out.
  assign emit      = work_vld_r && (!out_vld_r || !out_stall);
  assign emit_last = emit && (work_idx_r == work_r.last_idx);
  assign in_stall  = work_vld_r && !emit_last;
  assign in_acc    = in_valid && !in_stall;

  // Work register control.
  always_comb begin
    work_vld_nxt = work_vld_r;
    work_idx_nxt = work_idx_r;
    if (in_acc) begin
      work_vld_nxt = 1'b1;
      work_idx_nxt = '0;
    end else if (emit_last) begin
      work_vld_nxt = 1'b0;
    end else if (emit) begin
      work_idx_nxt = work_idx_r + 2'd1;
    end
  end

  // Output register control.
  assign out_vld_nxt = emit || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_vld_r    <= 1'b0;
      work_idx_r    <= '0;
      out_vld_r     <= 1'b0;
      frame_error_r <= 1'b0;
    end else begin
      work_vld_r <= work_vld_nxt;
      work_idx_r <= work_idx_nxt;
      out_vld_r  <= out_vld_nxt;
      if (in_acc) begin
        frame_error_r <= frame_error_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      work_r <= work_entry;
    end
    if (emit) begin
      out_r.out_byte   <= work_r.bytes[work_idx_r];
      out_r.run_last   <= (work_idx_r == work_r.last_idx);
      out_r.crc_ok     <= work_r.crc_ok;
      out_r.frame_ok   <= work_r.frame_ok;
      out_r.frame_done <= work_r.frame_done;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // The input is only held off while an item is still in the work register.
  a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> work_vld_r)
    else $error("input stalled with empty work register");

  // The result index never runs past the item's last result.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    work_vld_r |-> (work_idx_r <= work_r.last_idx))
    else $error("result index beyond last result");

  // A failed CRC always shows up as a frame failure.
  a_crc_fail_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.crc_ok) |-> !out_data.frame_ok)
    else $error("CRC failure without frame failure");

  // A transaction that is not the last of its item is followed by another result.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.run_last) |=> out_valid)
    else $error("result run broken before its last transaction");

endmodule

>>> sv/crc8rf_frame_build.sv
module crc8rf_frame_build
  import crc8rf_pkg::*;
(
  input  crc8rf_in_t   item,
  input  logic [6:0]   dev_addr,
  input  logic [7:0]   wr_crc,
  input  logic         frame_error,
  output crc8rf_work_t entry,
  output logic         frame_error_nxt
);

  logic [7:0] wr_addr;
  logic [7:0] rd_addr;
  logic [7:0] hdr_crc;
  logic [7:0] rd_hdr_crc;
  logic [7:0] wr_first_crc;
  logic [7:0] data_crc;
  logic [7:0] rd_crc;
  logic       rd_ok;
  logic       err_base;

  // Bus address bytes for both directions.
  assign wr_addr = {dev_addr, 1'b0};
  assign rd_addr = {dev_addr, RwReadBit};

  // The write address part of the header CRC arrives precomputed in wr_crc.
  assign hdr_crc      = crc8_update(wr_crc, item.reg_address);
  assign rd_hdr_crc   = crc8_update(hdr_crc, rd_addr);
  assign wr_first_crc = crc8_update(hdr_crc, item.data_byte);
  assign data_crc     = crc8_update(CrcInit, item.data_byte);
  assign rd_crc       = item.first_of_frame ? crc8_update(rd_hdr_crc, item.data_byte)
                                            : data_crc;
  assign rd_ok        = (rd_crc == item.crc_byte);

  // A new frame clears the sticky error before the item is checked.
  assign err_base = item.first_of_frame ? 1'b0 : frame_error;

  // Lay out the result bytes and flags for the command.
  always_comb begin
    entry            = '0;
    entry.frame_done = item.last_of_frame;
    frame_error_nxt  = err_base;
    unique case (item.command)
      CMD_WRITE: begin
        entry.crc_ok   = 1'b1;
        entry.frame_ok = 1'b1;
        if (item.first_of_frame) begin
          entry.bytes[0] = wr_addr;
          entry.bytes[1] = item.reg_address;
          entry.bytes[2] = item.data_byte;
          entry.bytes[3] = wr_first_crc;
          entry.last_idx = 2'd3;
        end else begin
          entry.bytes[0] = item.data_byte;
          entry.bytes[1] = data_crc;
          entry.last_idx = 2'd1;
        end
      end
      CMD_READ: begin
        frame_error_nxt = err_base | ~rd_ok;
        entry.bytes[0]  = item.data_byte;
        entry.last_idx  = 2'd0;
        entry.crc_ok    = rd_ok;
        entry.frame_ok  = ~(err_base | ~rd_ok);
      end
      default: begin
        entry.last_idx = 2'd0;
      end
    endcase
  end

endmodule

>>> tb/crc8_register_frame_codec_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the config port of the frame codec, works out the
// bytes each accepted transaction must produce and compares them in order.
module crc8_register_frame_codec_checker
  import crc8rf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  crc8rf_in_t        in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  crc8rf_out_t       out_data,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data,
  output int unsigned       mismatches,
  output int unsigned       outstanding
);

  localparam int unsigned PrintCap = 40;

  // Local copy of the device address and the sticky read error.
  logic [6:0]  bus_addr;
  logic        frame_err;
  crc8rf_out_t expected_bytes[$];
  crc8rf_out_t want;

  // Bit-serial CRC-8, most significant bit first.
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r = {r[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return r;
  endfunction

  // Prints one line per mismatch (up to a cap) and counts every one.
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_val);
    mismatches++;
    if (mismatches <= PrintCap) begin
      $display("%0t ns: %s mismatch: got %02h, expected %02h", $time, what, got, exp_val);
    end
  endtask

  // Expands one accepted transaction into the result bytes it must produce.
  task automatic queue_frame_bytes(input crc8rf_in_t it);
    logic [7:0]  wr_addr;
    logic [7:0]  rd_addr;
    logic [7:0]  crc;
    logic        match;
    crc8rf_out_t r;
    wr_addr = {bus_addr, 1'b0};
    rd_addr = {bus_addr, RwReadBit};
    crc = CrcInit;
    if (it.first_of_frame) begin
      frame_err = 1'b0;
    end
    r.run_last = 1'b0;
    r.crc_ok = 1'b1;
    r.frame_ok = 1'b1;
    r.frame_done = it.last_of_frame;
    if (it.command == CMD_WRITE) begin
      // A frame opener carries the bus header ahead of the data byte.
      if (it.first_of_frame) begin
        crc = crc8_next(crc8_next(crc8_next(crc, wr_addr), it.reg_address), it.data_byte);
        r.out_byte = wr_addr;
        expected_bytes.push_back(r);
        r.out_byte = it.reg_address;
        expected_bytes.push_back(r);
      end else begin
        crc = crc8_next(crc, it.data_byte);
      end
      r.out_byte = it.data_byte;
      expected_bytes.push_back(r);
      r.out_byte = crc;
      r.run_last = 1'b1;
      expected_bytes.push_back(r);
    end else begin
      // The first read pair is covered together with the addressing bytes.
      if (it.first_of_frame) begin
        crc = crc8_next(crc8_next(crc8_next(crc, wr_addr), it.reg_address), rd_addr);
      end
      crc = crc8_next(crc, it.data_byte);
      match = (crc == it.crc_byte);
      if (!match) begin
        frame_err = 1'b1;
      end
      r.out_byte = it.data_byte;
      r.run_last = 1'b1;
      r.crc_ok = match;
      r.frame_ok = !frame_err;
      expected_bytes.push_back(r);
    end
  endtask

  // Sample both channels at each rising edge; results are retired before new
  // transactions are expanded, since a result never comes in the cycle of its item.
  always @(posedge clk) begin
    if (!rst_n) begin
      bus_addr = '0;
      frame_err = 1'b0;
      expected_bytes.delete();
    end else begin
      if (cfg_wr_en) begin
        bus_addr = cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected result, out_byte", out_data.out_byte, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            report_mismatch("out_byte", out_data.out_byte, want.out_byte);
          end
          if (out_data.run_last !== want.run_last) begin
            report_mismatch("run_last", 8'(out_data.run_last), 8'(want.run_last));
          end
          if (out_data.crc_ok !== want.crc_ok) begin
            report_mismatch("crc_ok", 8'(out_data.crc_ok), 8'(want.crc_ok));
          end
          if (out_data.frame_ok !== want.frame_ok) begin
            report_mismatch("frame_ok", 8'(out_data.frame_ok), 8'(want.frame_ok));
          end
          if (out_data.frame_done !== want.frame_done) begin
            report_mismatch("frame_done", 8'(out_data.frame_done), 8'(want.frame_done));
          end
        end
      end
      if (in_valid && !in_stall) begin
        queue_frame_bytes(in_data);
      end
    end
    outstanding <= expected_bytes.size();
  end

endmodule

>>> tb/crc8_register_frame_codec_core_tb.sv
`timescale 1ns / 1ps

module crc8_register_frame_codec_core_tb
  import crc8rf_pkg::*;
();

  localparam int ClkPeriod   = 20;
  localparam int ResetCycles = 11;
  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 80;
  localparam int SettleCycles = 4;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  crc8rf_in_t  in_data;
  logic        out_valid;
  logic        out_stall;
  crc8rf_out_t out_data;
  logic        cfg_wr_en;
  logic [6:0]  cfg_wr_data;

  int unsigned mismatches;
  int unsigned outstanding;

  // Stimulus-side copy of the device address, used to build valid read CRCs.
  logic [6:0]  dev_addr;
  bit          calm = 1'b0;
  int unsigned in_gap_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  crc8_register_frame_codec_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  crc8_register_frame_codec_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Hard stop if the run hangs.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Receiver side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        out_stall <= 1'b1;
        for (int n = 0; n < HoldCycles; n++) @(posedge clk);
        out_stall <= 1'b0;
        holds_done++;
      end else if (!calm && out_stall_pct > 0 && $urandom_range(0, 99) < out_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic crc8rf_in_t make_item(input crc8rf_cmd_t cmd, input logic first,
                                           input logic last, input logic [7:0] reg_a,
                                           input logic [7:0] data, input logic [7:0] crc);
    crc8rf_in_t it;
    it.command = cmd;
    it.reg_address = reg_a;
    it.data_byte = data;
    it.crc_byte = crc;
    it.first_of_frame = first;
    it.last_of_frame = last;
    return it;
  endfunction

  // CRC that a well-behaved chip would send with a read pair.
  function automatic logic [7:0] read_crc(input logic first, input logic [7:0] reg_a,
                                          input logic [7:0] data);
    logic [7:0] c;
    c = CrcInit;
    if (first) begin
      c = crc8_update(crc8_update(crc8_update(c, {dev_addr, 1'b0}), reg_a),
                      {dev_addr, RwReadBit});
    end
    return crc8_update(c, data);
  endfunction

  // Offers one transaction, with an optional idle burst first, and returns at
  // the edge where it is accepted.
  task automatic send_item(input crc8rf_in_t it);
    if (!calm && in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Stops offering and waits until every expected result has been seen.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic set_device_address(input logic [6:0] addr);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= addr;
    dev_addr = addr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One frame with random content. Mostly well formed with correct read CRCs;
  // a broken frame mixes commands and scrambles the frame marks.
  task automatic send_random_frame(input bit broken);
    int unsigned len;
    crc8rf_cmd_t frame_cmd;
    crc8rf_in_t  it;
    logic [7:0]  reg_a;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
    frame_cmd = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
    reg_a = 8'($urandom);
    for (int k = 0; k < len; k++) begin
      it.command = frame_cmd;
      if (broken && $urandom_range(0, 3) == 0) begin
        it.command = (frame_cmd == CMD_WRITE) ? CMD_READ : CMD_WRITE;
      end
      it.reg_address = (k == 0) ? reg_a : 8'($urandom);
      it.data_byte = 8'($urandom);
      it.first_of_frame = (k == 0);
      it.last_of_frame = (k == len - 1);
      if (broken) begin
        it.first_of_frame = 1'($urandom_range(0, 1));
        it.last_of_frame = 1'($urandom_range(0, 1));
      end
      if (it.command == CMD_READ && $urandom_range(0, 7) != 0) begin
        it.crc_byte = read_crc(it.first_of_frame, it.reg_address, it.data_byte);
      end else begin
        it.crc_byte = 8'($urandom);
      end
      send_item(it);
    end
  endtask

  // One random phase under a given address and idle density.
  task automatic run_random_phase(input logic [6:0] addr, input int unsigned n_items,
                                  input int unsigned gap_pct, input int unsigned stall_pct,
                                  input bit long_hold);
    int unsigned stop_at;
    set_device_address(addr);
    in_gap_pct = gap_pct;
    out_stall_pct = stall_pct;
    if (long_hold) begin
      hold_requests++;
    end
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      send_random_frame($urandom_range(0, 9) == 0);
    end
    wait_drained();
  endtask

  // Stimulus and verdict.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    dev_addr = '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: the reset address first, with all-zero bytes.
    send_item(make_item(CMD_WRITE, 1'b1, 1'b1, 8'h00, 8'h00, 8'hFF));
    send_item(make_item(CMD_READ, 1'b1, 1'b1, 8'h00, 8'h00, read_crc(1'b1, 8'h00, 8'h00)));
    wait_drained();
    set_device_address(7'h7F);

    // Multi-byte write frame; unused fields on later bytes carry junk.
    send_item(make_item(CMD_WRITE, 1'b1, 1'b0, 8'hFF, 8'hFF, 8'h00));
    send_item(make_item(CMD_WRITE, 1'b0, 1'b0, 8'h00, 8'h00, 8'hFF));
    send_item(make_item(CMD_WRITE, 1'b0, 1'b1, 8'hAA, 8'hFF, 8'h5A));

    // Read frame where a bad pair makes the error flag stick to the end.
    send_item(make_item(CMD_READ, 1'b1, 1'b0, 8'h3C, 8'hA5, read_crc(1'b1, 8'h3C, 8'hA5)));
    send_item(make_item(CMD_READ, 1'b0, 1'b0, 8'h11, 8'h00,
                        read_crc(1'b0, 8'h11, 8'h00) ^ 8'h01));
    send_item(make_item(CMD_READ, 1'b0, 1'b1, 8'h22, 8'hFF, read_crc(1'b0, 8'h22, 8'hFF)));

    // A new read frame clears the flag.
    send_item(make_item(CMD_READ, 1'b1, 1'b1, 8'hFF, 8'hFF, read_crc(1'b1, 8'hFF, 8'hFF)));

    // A write opener also clears the flag, and a later good read stays clean.
    send_item(make_item(CMD_READ, 1'b1, 1'b0, 8'h12, 8'h34,
                        read_crc(1'b1, 8'h12, 8'h34) ^ 8'h80));
    send_item(make_item(CMD_WRITE, 1'b1, 1'b0, 8'h56, 8'h78, 8'h00));
    send_item(make_item(CMD_READ, 1'b0, 1'b1, 8'h00, 8'h9A, read_crc(1'b0, 8'h00, 8'h9A)));

    // Items with neither frame mark, and single-item frames at the extremes.
    send_item(make_item(CMD_READ, 1'b0, 1'b0, 8'hFF, 8'h00, 8'h00));
    send_item(make_item(CMD_READ, 1'b1, 1'b1, 8'h80, 8'h01, 8'hFF));
    send_item(make_item(CMD_READ, 1'b1, 1'b0, 8'h01, 8'h80, read_crc(1'b1, 8'h01, 8'h80)));
    send_item(make_item(CMD_WRITE, 1'b0, 1'b0, 8'h7F, 8'h7F, 8'h80));
    send_item(make_item(CMD_READ, 1'b0, 1'b0, 8'h00, 8'hFF, 8'h00));
    wait_drained();

    // Random phases: light idling, then a long receiver hold-off with no other
    // idling, then heavy idling, and finally a stretch with none at all.
    run_random_phase(7'h00, 50, 20, 20, 1'b0);
    run_random_phase(7'($urandom), 50, 0, 0, 1'b1);
    run_random_phase(7'h55, 45, 40, 40, 1'b0);
    calm = 1'b1;
    run_random_phase(7'h7F, 50, 0, 0, 1'b0);

    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
sv/crc8rf_pkg.sv
sv/crc8rf_frame_build.sv
sv/crc8_register_frame_codec_core.sv
tb/crc8_register_frame_codec_checker.sv
tb/crc8_register_frame_codec_core_tb.sv
